// ===== rtl/core/byss_pkg.sv =====
`timescale 1ns / 1ps

package byss_pkg;

    localparam int RATE_W  = 48;
    localparam int CNT_W   = 20;
    localparam int TOL_W   = 25;
    localparam int STEP_W  = 41;
    localparam int PRICE_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 41;

    localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd2;

    localparam logic [TOL_W-1:0]  TOL_RESET   = 25'd1;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = 20'd1000000;
    localparam logic [STEP_W-1:0] STEP_RESET  = 41'd54975581389;

    typedef struct packed {
        logic [31:0]        coupon_rate;
        logic [7:0]         periods;
        logic [PRICE_W-1:0] face_value;
        logic [PRICE_W-1:0] target_price;
    } t_in_item;

    typedef struct packed {
        logic signed [RATE_W-1:0] yield_rate;
        logic [CNT_W-1:0]         iterations_used;
        logic                     failed;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_CPN,
        OP_SET_CPN,
        OP_DIV_Q,
        OP_SET_Q,
        OP_Q_ZERO,
        OP_SET_NUM,
        OP_DIV_G,
        OP_SET_G,
        OP_G_ZERO,
        OP_LIMIT_FAIL,
        OP_RATE_FAIL,
        OP_DIV_D,
        OP_SET_D,
        OP_MUL_H,
        OP_SET_H,
        OP_UPDATE,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic n_zero;
        logic sum_zero;
        logic limit_hit;
        logic rate_bad;
        logic period_last;
        logic in_tol;
    } t_sts;

endpackage

// ===== rtl/core/byss_mul.sv =====
`timescale 1ns / 1ps

module byss_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic         r_busy;
    logic [1:0]   r_k;
    logic         r_pp_v;
    logic [1:0]   r_pp_k;
    logic         r_done;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [127:0] r_acc;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] pp_shift;

    assign a_part = r_k[0] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_k[1] ? r_b[63:32] : r_b[31:0];

    always_comb begin
        pp_shift = 128'(r_pp) << (7'(r_pp_k[0]) * 7'd32 + 7'(r_pp_k[1]) * 7'd32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
            r_pp_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_pp_v && (r_pp_k == 2'd3);
            r_pp_v <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 2'd0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_pp_v) begin
            r_acc <= r_acc + pp_shift;
        end
        r_pp   <= 64'(a_part) * 64'(b_part);
        r_pp_k <= r_k;
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/byss_div.sv =====
`timescale 1ns / 1ps

module byss_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    output logic         o_done,
    output logic [63:0]  o_quo
);

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [63:0]  r_q;
    logic         r_sat;
    logic [64:0]  rem_s;
    logic         fits;

    assign rem_s = {r_rem, r_num[127]};
    assign fits  = rem_s >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            if (r_q[63]) begin
                r_sat <= 1'b1;
            end
            r_q   <= {r_q[62:0], fits};
            r_rem <= fits ? 64'(rem_s - {1'b0, r_den}) : rem_s[63:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sat ? '1 : r_q;

endmodule

// ===== rtl/core/byss_dp.sv =====
`timescale 1ns / 1ps

module byss_dp #(
    parameter int MAX_PERIODS    = 128,
    parameter int RATE_FRAC_BITS = 40
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [byss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [byss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  byss_pkg::t_in_item                  i_in_item,
    input  byss_pkg::t_op                       i_op,
    output byss_pkg::t_sts                      o_sts,
    output byss_pkg::t_out_item                 o_out_item
);

    localparam int PC_W = $clog2(MAX_PERIODS + 1);
    localparam int RW   = byss_pkg::RATE_W;
    localparam int PW   = byss_pkg::PRICE_W;
    localparam int CW   = byss_pkg::CNT_W;
    localparam logic [RW-1:0] RATE_MAXV = {1'b0, {(RW-1){1'b1}}};
    localparam logic [RW-1:0] RATE_MINV = {1'b1, {(RW-1){1'b0}}};

    logic [byss_pkg::TOL_W-1:0]  r_tol;
    logic [CW-1:0]               r_limit;
    logic [byss_pkg::STEP_W-1:0] r_istep;

    logic [31:0]          r_coupon;
    logic [PC_W-1:0]      r_n;
    logic [PW-1:0]        r_face;
    logic [PW-1:0]        r_target;
    logic                 r_diff_neg;
    logic [PW-1:0]        r_dabs;
    logic [PW:0]          r_sum;
    logic [PW-1:0]        r_cpn;
    logic signed [PW+1:0] r_q;
    logic [PW+1:0]        r_mag;
    logic                 r_num_neg;
    logic [RW-1:0]        r_rate;
    logic [RW-1:0]        r_step;
    logic                 r_up;
    logic [CW-1:0]        r_count;
    logic [63:0]          r_acc;
    logic [PC_W-1:0]      r_pc;
    logic [63:0]          r_d;
    logic                 r_fail;
    byss_pkg::t_out_item  r_out;

    logic [PW:0]          ld_diff;
    logic [PW:0]          ld_sum;
    logic [PC_W-1:0]      ld_n;
    logic [RW:0]          rate_ext;
    logic [RW:0]          den_sum;
    logic                 rate_bad;
    logic [64:0]          s65;
    logic [63:0]          hsum;
    logic [127:0]         p_sh;
    logic [63:0]          h_acc;
    logic [63:0]          tgt64;
    logic                 below;
    logic [63:0]          err;
    logic [RW:0]          step_ext;
    logic [RW:0]          upd_sub;
    logic [RW:0]          upd_add;
    logic [RW-1:0]        sub_rate;
    logic [RW-1:0]        add_rate;
    logic [RW-1:0]        g_mag;
    logic [RW-1:0]        g_rate;
    logic [PW+1:0]        q50;
    logic [PW+1:0]        num;
    logic [PW+1:0]        num_mag;

    logic         mul_start;
    logic [63:0]  mul_a;
    logic [63:0]  mul_b;
    logic         mul_done;
    logic [127:0] mul_prod;
    logic         div_start;
    logic [127:0] div_num;
    logic [63:0]  div_den;
    logic         div_done;
    logic [63:0]  div_quo;

    byss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    byss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        ld_diff = (PW+1)'(i_in_item.target_price) - (PW+1)'(i_in_item.face_value);
        ld_sum  = (PW+1)'(i_in_item.target_price) + (PW+1)'(i_in_item.face_value);
        ld_n    = (32'(i_in_item.periods) > MAX_PERIODS) ? PC_W'(MAX_PERIODS)
                                                       : PC_W'(i_in_item.periods);

        rate_ext = {r_rate[RW-1], r_rate};
        den_sum  = ((RW+1)'(1) << RATE_FRAC_BITS) + rate_ext;
        rate_bad = den_sum[RW] || (den_sum == '0);

        s65   = {1'b0, r_acc} + 65'(r_cpn);
        hsum  = s65[64] ? '1 : s65[63:0];
        p_sh  = mul_prod >> RATE_FRAC_BITS;
        h_acc = (|p_sh[127:64]) ? '1 : p_sh[63:0];

        tgt64 = 64'(r_target);
        below = r_acc < tgt64;
        err   = below ? (tgt64 - r_acc) : (r_acc - tgt64);

        step_ext = {1'b0, r_step};
        upd_sub  = rate_ext - step_ext;
        upd_add  = rate_ext + step_ext;
        sub_rate = (upd_sub[RW] != upd_sub[RW-1]) ? RATE_MINV : upd_sub[RW-1:0];
        add_rate = (upd_add[RW] != upd_add[RW-1]) ? RATE_MAXV : upd_add[RW-1:0];

        g_mag  = (div_quo > 64'(RATE_MAXV)) ? RATE_MAXV : div_quo[RW-1:0];
        g_rate = r_num_neg ? (RW'(0) - g_mag) : g_mag;

        q50     = r_diff_neg ? ((PW+2)'(0) - (PW+2)'(div_quo[PW-1:0]))
                             : (PW+2)'(div_quo[PW-1:0]);
        num     = (PW+2)'(r_cpn) - r_q;
        num_mag = num[PW+1] ? ((PW+2)'(0) - num) : num;
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (i_op)
            byss_pkg::OP_MUL_CPN: begin
                mul_start = 1'b1;
                mul_a     = 64'(r_coupon);
                mul_b     = 64'(r_face);
            end
            byss_pkg::OP_MUL_H: begin
                mul_start = 1'b1;
                mul_a     = hsum;
                mul_b     = r_d;
            end
            byss_pkg::OP_DIV_Q: begin
                div_start = 1'b1;
                div_num   = 128'(r_dabs);
                div_den   = 64'(r_n);
            end
            byss_pkg::OP_DIV_G: begin
                div_start = 1'b1;
                div_num   = 128'(r_mag) << (RATE_FRAC_BITS + 1);
                div_den   = 64'(r_sum);
            end
            byss_pkg::OP_DIV_D: begin
                div_start = 1'b1;
                div_num   = 128'(1) << (2 * RATE_FRAC_BITS);
                div_den   = 64'(den_sum);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= byss_pkg::TOL_RESET;
            r_limit <= byss_pkg::LIMIT_RESET;
            r_istep <= byss_pkg::STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                byss_pkg::CFG_TOL:   r_tol   <= i_cfg_data[byss_pkg::TOL_W-1:0];
                byss_pkg::CFG_LIMIT: r_limit <= i_cfg_data[CW-1:0];
                byss_pkg::CFG_STEP:  r_istep <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            byss_pkg::OP_LOAD: begin
                r_coupon   <= i_in_item.coupon_rate;
                r_n        <= ld_n;
                r_face     <= i_in_item.face_value;
                r_target   <= i_in_item.target_price;
                r_diff_neg <= ld_diff[PW];
                r_dabs     <= ld_diff[PW] ? PW'((PW+1)'(0) - ld_diff) : ld_diff[PW-1:0];
                r_sum      <= ld_sum;
                r_step     <= RW'(r_istep);
                r_up       <= 1'b1;
                r_count    <= '0;
                r_fail     <= 1'b0;
            end
            byss_pkg::OP_SET_CPN: r_cpn <= mul_prod[32+PW-1:32];
            byss_pkg::OP_SET_Q:   r_q   <= q50;
            byss_pkg::OP_Q_ZERO:  r_q   <= '0;
            byss_pkg::OP_SET_NUM: begin
                r_mag     <= num_mag;
                r_num_neg <= num[PW+1];
            end
            byss_pkg::OP_SET_G:  r_rate <= g_rate;
            byss_pkg::OP_G_ZERO: r_rate <= '0;
            byss_pkg::OP_LIMIT_FAIL: begin
                r_count <= (r_limit == '1) ? '1 : r_limit + CW'(1);
                r_fail  <= 1'b1;
            end
            byss_pkg::OP_RATE_FAIL: r_fail <= 1'b1;
            byss_pkg::OP_SET_D: begin
                r_d     <= div_quo;
                r_acc   <= 64'(r_face);
                r_pc    <= '0;
                r_count <= r_count + CW'(1);
            end
            byss_pkg::OP_SET_H: begin
                r_acc <= h_acc;
                r_pc  <= r_pc + PC_W'(1);
            end
            byss_pkg::OP_UPDATE: begin
                if (below) begin
                    r_rate <= sub_rate;
                    if (r_up) begin
                        r_step <= r_step >> 1;
                        r_up   <= 1'b0;
                    end
                end else begin
                    r_rate <= add_rate;
                    if (!r_up) begin
                        r_step <= r_step >> 1;
                        r_up   <= 1'b1;
                    end
                end
            end
            byss_pkg::OP_OUT: begin
                r_out.yield_rate      <= r_fail ? (RW'(0) - (RW'(1) << RATE_FRAC_BITS))
                                                : r_rate;
                r_out.iterations_used <= r_count;
                r_out.failed          <= r_fail;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.mul_done    = mul_done;
        o_sts.div_done    = div_done;
        o_sts.n_zero      = (r_n == '0);
        o_sts.sum_zero    = (r_sum == '0);
        o_sts.limit_hit   = (r_count >= r_limit);
        o_sts.rate_bad    = rate_bad;
        o_sts.period_last = (r_pc == r_n);
        o_sts.in_tol      = (err <= 64'(r_tol));
    end

    assign o_out_item = r_out;

endmodule

// ===== rtl/core/byss_ctrl.sv =====
`timescale 1ns / 1ps

module byss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  byss_pkg::t_sts  i_sts,
    output byss_pkg::t_op   o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CPN_START,
        S_CPN_WAIT,
        S_Q_START,
        S_Q_WAIT,
        S_NUM,
        S_G_START,
        S_G_WAIT,
        S_CHECK,
        S_D_WAIT,
        S_P_CHECK,
        S_H_WAIT,
        S_FINISH
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic          r_out_valid;
    logic          n_out_valid;
    byss_pkg::t_op op;

    always_comb begin
        n_state     = r_state;
        op          = byss_pkg::OP_NONE;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = byss_pkg::OP_LOAD;
                    n_state = S_CPN_START;
                end
            end
            S_CPN_START: begin
                op      = byss_pkg::OP_MUL_CPN;
                n_state = S_CPN_WAIT;
            end
            S_CPN_WAIT: begin
                if (i_sts.mul_done) begin
                    op      = byss_pkg::OP_SET_CPN;
                    n_state = S_Q_START;
                end
            end
            S_Q_START: begin
                if (i_sts.n_zero) begin
                    op      = byss_pkg::OP_Q_ZERO;
                    n_state = S_NUM;
                end else begin
                    op      = byss_pkg::OP_DIV_Q;
                    n_state = S_Q_WAIT;
                end
            end
            S_Q_WAIT: begin
                if (i_sts.div_done) begin
                    op      = byss_pkg::OP_SET_Q;
                    n_state = S_NUM;
                end
            end
            S_NUM: begin
                op      = byss_pkg::OP_SET_NUM;
                n_state = S_G_START;
            end
            S_G_START: begin
                if (i_sts.sum_zero) begin
                    op      = byss_pkg::OP_G_ZERO;
                    n_state = S_CHECK;
                end else begin
                    op      = byss_pkg::OP_DIV_G;
                    n_state = S_G_WAIT;
                end
            end
            S_G_WAIT: begin
                if (i_sts.div_done) begin
                    op      = byss_pkg::OP_SET_G;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.limit_hit) begin
                    op      = byss_pkg::OP_LIMIT_FAIL;
                    n_state = S_FINISH;
                end else if (i_sts.rate_bad) begin
                    op      = byss_pkg::OP_RATE_FAIL;
                    n_state = S_FINISH;
                end else begin
                    op      = byss_pkg::OP_DIV_D;
                    n_state = S_D_WAIT;
                end
            end
            S_D_WAIT: begin
                if (i_sts.div_done) begin
                    op      = byss_pkg::OP_SET_D;
                    n_state = S_P_CHECK;
                end
            end
            S_P_CHECK: begin
                if (!i_sts.period_last) begin
                    op      = byss_pkg::OP_MUL_H;
                    n_state = S_H_WAIT;
                end else if (i_sts.in_tol) begin
                    n_state = S_FINISH;
                end else begin
                    op      = byss_pkg::OP_UPDATE;
                    n_state = S_CHECK;
                end
            end
            S_H_WAIT: begin
                if (i_sts.mul_done) begin
                    op      = byss_pkg::OP_SET_H;
                    n_state = S_P_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    op          = byss_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_op        = op;

endmodule

// ===== rtl/core/bond_yield_step_search.sv =====
`timescale 1ns / 1ps
// bond yield search: one bond item in, one yield item out
// input channel i_in_valid / o_in_ready carries coupon, periods, face and price
// output channel o_out_valid / i_out_ready carries yield, iteration count, failed flag
// config port i_cfg_we / i_cfg_idx / i_cfg_data writes tolerance, limit and first step
// one item is worked at a time; o_in_ready is high only while the block is idle
// setup runs a coupon product and up to two 128-step divisions
// each repricing runs a 128-step divider for the discount factor, then
// one 4-pass 32x32 multiply per period
// repricing repeats up to the iteration limit
// the result sits in an output register; a new item is accepted while it waits
// a stalled receiver holds the result; the next item then waits to finish
// reset (synchronous, active low) empties the block and restores config defaults
module bond_yield_step_search #(
    parameter int MAX_PERIODS    = 128,
    parameter int RATE_FRAC_BITS = 40
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [byss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [byss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  byss_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output byss_pkg::t_out_item             o_out_item
);

    byss_pkg::t_sts sts;
    byss_pkg::t_op  op;

    byss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_op        (op)
    );

    byss_dp #(
        .MAX_PERIODS    (MAX_PERIODS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_item  (i_in_item),
        .i_op       (op),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

// ===== rtl/core/byss_chk.sv =====
`timescale 1ns / 1ps

module byss_chk #(
    parameter int RATE_FRAC_BITS = 40
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input byss_pkg::t_out_item             o_out_item
);

    localparam int RW = byss_pkg::RATE_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.failed |->
            o_out_item.yield_rate == (RW'(0) - (RW'(1) << RATE_FRAC_BITS)))
        else $error("failed item without minus one yield");

    a_success_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.failed |-> o_out_item.iterations_used != '0)
        else $error("converged item with zero repricings");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accepting an item");

endmodule

bind bond_yield_step_search byss_chk #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_chk (.*);

// ===== tb/bond_yield_step_search_checker.sv =====
`timescale 1ns / 1ps

module bond_yield_step_search_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [byss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [byss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  byss_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  byss_pkg::t_out_item             i_out_item,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    localparam longint YIELD_MAX = 64'sd140737488355327;
    localparam longint YIELD_MIN = -64'sd140737488355328;
    localparam longint ONE_RATE  = 64'sd1099511627776;

    logic [byss_pkg::TOL_W-1:0]  tolerance;
    logic [byss_pkg::CNT_W-1:0]  max_iters;
    logic [byss_pkg::STEP_W-1:0] first_step;
    byss_pkg::t_out_item         yield_queue[$];

    function automatic longint unsigned price_at(longint unsigned cpn, longint unsigned n,
                                                 longint unsigned face, longint rate);
        longint unsigned den, disc, acc, s;
        logic [127:0]    w;
        den  = longint'(ONE_RATE + rate);
        w    = (128'd1 << 80) / 128'(den);
        disc = (w[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0];
        acc  = face;
        for (longint unsigned i = 0; i < n; i++) begin
            s = acc + cpn;
            if (s < cpn) s = 64'hFFFF_FFFF_FFFF_FFFF;
            w   = (128'(s) * 128'(disc)) >> 40;
            acc = (w[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0];
        end
        return acc;
    endfunction

    function automatic byss_pkg::t_out_item solve_bond(byss_pkg::t_in_item b);
        longint unsigned     n, cpn, sum, mag, stp, price, err, face, target, iters;
        longint              diff, q, num, rate;
        logic [127:0]        w;
        logic                up, fail;
        byss_pkg::t_out_item r;
        face   = b.face_value;
        target = b.target_price;
        n      = b.periods;
        if (n > 128) n = 128;
        w    = 128'(b.coupon_rate) * 128'(face);
        cpn  = w[95:32];
        diff = longint'(target) - longint'(face);
        q    = (n != 0) ? diff / longint'(n) : 0;
        num  = longint'(cpn) - q;
        sum  = target + face;
        mag  = (num < 0) ? longint'(-num) : longint'(num);
        if (sum == 0) begin
            mag = 0;
        end else begin
            w   = (128'(mag) << 41) / 128'(sum);
            mag = (w[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : w[63:0];
        end
        if (mag > longint'(YIELD_MAX)) mag = YIELD_MAX;
        rate  = (num < 0) ? -longint'(mag) : longint'(mag);
        stp   = first_step;
        up    = 1'b1;
        iters = 0;
        fail  = 1'b0;
        forever begin
            if (iters >= max_iters) begin
                iters = (max_iters >= 20'hFFFFF) ? 20'hFFFFF : max_iters + 1;
                fail  = 1'b1;
                break;
            end
            if (ONE_RATE + rate <= 0) begin
                fail = 1'b1;
                break;
            end
            price = price_at(cpn, n, face, rate);
            iters++;
            err = (price < target) ? target - price : price - target;
            if (err <= tolerance) break;
            if (price < target) begin
                rate -= longint'(stp);
                if (rate < YIELD_MIN) rate = YIELD_MIN;
                if (up) begin
                    stp >>= 1;
                    up = 1'b0;
                end
            end else begin
                rate += longint'(stp);
                if (rate > YIELD_MAX) rate = YIELD_MAX;
                if (!up) begin
                    stp >>= 1;
                    up = 1'b1;
                end
            end
        end
        r.yield_rate      = fail ? 48'(-ONE_RATE) : rate[47:0];
        r.iterations_used = iters[19:0];
        r.failed          = fail;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        byss_pkg::t_out_item want;
        if (!i_rst_n) begin
            tolerance    <= byss_pkg::TOL_RESET;
            max_iters    <= byss_pkg::LIMIT_RESET;
            first_step   <= byss_pkg::STEP_RESET;
            o_fail_count <= 0;
            o_checked    <= 0;
            yield_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    byss_pkg::CFG_TOL: begin
                        tolerance <= i_cfg_data[byss_pkg::TOL_W-1:0];
                    end
                    byss_pkg::CFG_LIMIT: begin
                        max_iters <= i_cfg_data[byss_pkg::CNT_W-1:0];
                    end
                    byss_pkg::CFG_STEP: begin
                        first_step <= i_cfg_data[byss_pkg::STEP_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) yield_queue.push_back(solve_bond(i_in_item));
            if (i_out_valid && i_out_ready) begin
                o_checked <= o_checked + 1;
                if (yield_queue.size() == 0) begin
                    $error("unexpected result item %p", i_out_item);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = yield_queue.pop_front();
                    if (want != i_out_item) o_fail_count <= o_fail_count + 1;
                    if (want.yield_rate != i_out_item.yield_rate)
                        $error("yield_rate expected %0d got %0d",
                               want.yield_rate, i_out_item.yield_rate);
                    if (want.iterations_used != i_out_item.iterations_used)
                        $error("iterations_used expected %0d got %0d",
                               want.iterations_used, i_out_item.iterations_used);
                    if (want.failed != i_out_item.failed)
                        $error("failed expected %0d got %0d", want.failed, i_out_item.failed);
                end
            end
        end
    end

    assign o_pending = yield_queue.size();

endmodule

// ===== tb/bond_yield_step_search_tb.sv =====
`timescale 1ns / 1ps

module bond_yield_step_search_tb;

    localparam longint CYCLE_LIMIT = 20000000;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [byss_pkg::CFG_IDX_W-1:0]  cfg_idx = byss_pkg::CFG_TOL;
    logic [byss_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    byss_pkg::t_in_item              in_item = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    byss_pkg::t_out_item             out_item;
    int                              fail_count, pending, checked;
    int                              bonds_sent = 0;
    int                              settings_run = 0;
    bit                              quiet = 1'b0;
    longint                          cycles = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bond_yield_step_search i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    bond_yield_step_search_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        wait (rst_n);
        forever begin
            @(negedge clk);
            out_ready = 1'b0;
            repeat (quiet ? 0 : $urandom_range(0, 13)) @(negedge clk);
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic write_reg(logic [byss_pkg::CFG_IDX_W-1:0] idx,
                             logic [byss_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_search(logic [byss_pkg::TOL_W-1:0] tol, logic [byss_pkg::CNT_W-1:0] lim,
                              logic [byss_pkg::STEP_W-1:0] stp);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        write_reg(byss_pkg::CFG_TOL, byss_pkg::CFG_DATA_W'(tol));
        write_reg(byss_pkg::CFG_LIMIT, byss_pkg::CFG_DATA_W'(lim));
        write_reg(byss_pkg::CFG_STEP, byss_pkg::CFG_DATA_W'(stp));
        settings_run++;
    endtask

    task automatic send_bond(logic [31:0] cpn, logic [7:0] n, logic [47:0] face,
                             logic [47:0] price);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = '{coupon_rate: cpn, periods: n, face_value: face, target_price: price};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bonds_sent++;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic random_bond();
        logic [47:0] face, price;
        logic [7:0]  n;
        if ($urandom_range(0, 9) == 0) begin
            n = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 12));
            send_bond($urandom(), n, rand48(), rand48());
        end else begin
            n     = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(13, 255))
                                                 : 8'($urandom_range(1, 12));
            face  = 48'($urandom_range(50, 1000)) << 24;
            price = 48'(longint'(face) * $urandom_range(60, 140) / 100
                        + $urandom_range(0, 16777215));
            send_bond($urandom_range(0, 429496729), n, face, price);
        end
    endtask

    initial begin
        logic [byss_pkg::TOL_W-1:0]  tol;
        logic [byss_pkg::STEP_W-1:0] stp;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // immediate exits under the default limit: exact price, invalid guess, zero sum
        set_search(25'd16777216, 20'd1000000, 41'd1099511627776);
        send_bond(32'd0, 8'd1, 48'd1 << 24, 48'd1 << 24);
        send_bond(32'd0, 8'd0, 48'd5 << 24, 48'd5 << 24);
        send_bond(32'd0, 8'd1, 48'd1 << 24, 48'd100 << 24);
        send_bond(32'd0, 8'd0, 48'd0, 48'd0);
        send_bond(32'hFFFF_FFFF, 8'd0, 48'd7 << 24, 48'd7 << 24);

        // field extremes, long maturities, step running down to zero
        set_search(25'd0, 20'd3, 41'd1);
        send_bond(32'hFFFF_FFFF, 8'd255, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_bond(32'hFFFF_FFFF, 8'd128, 48'hFFFF_FFFF_FFFF, 48'd1);
        send_bond(32'd0, 8'd200, 48'd1, 48'hFFFF_FFFF_FFFF);
        send_bond(32'd42949673, 8'd129, 48'd100 << 24, 48'd95 << 24);
        send_bond(32'd0, 8'd1, 48'hFFFF_FFFF_FFFF, 48'd1);
        send_bond(32'd21474836, 8'd10, 48'd100 << 24, 48'd105 << 24);
        send_bond(32'd21474836, 8'd0, 48'd100 << 24, 48'd90 << 24);

        set_search(25'd0, 20'd1, 41'd54975581389);
        send_bond(32'd42949673, 8'd5, 48'd100 << 24, 48'd100 << 24);
        send_bond(32'hFFFF_FFFF, 8'd1, 48'd1, 48'd1);

        for (int p = 0; p < 8; p++) begin
            case ($urandom_range(0, 3))
                0: tol = 25'd0;
                1: tol = 25'd1;
                2: tol = 25'($urandom_range(0, 16777216));
                default: tol = 25'd16777216;
            endcase
            case ($urandom_range(0, 3))
                0: stp = 41'd1;
                1: stp = 41'd1099511627776;
                2: stp = 41'd54975581389;
                default: stp = 41'({$urandom(), $urandom()}) & 41'h1FF_FFFF_FFFF;
            endcase
            if (stp == 0) stp = 41'd1;
            set_search(tol, 20'($urandom_range(4, 40)), stp);
            quiet = (p % 3 == 1);
            repeat (12) random_bond();
        end
        quiet    = 1'b0;
        in_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("%0d bonds sent over %0d search settings, %0d yields checked",
                 bonds_sent, settings_run, checked);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
